/* sv/ffwq_pkg.sv */
`default_nettype none

package ffwq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF    = 32;
    localparam int SIZE_BITS_DEF   = 8;

    localparam int FUNC_W   = 2;
    localparam int IN_TAG_W = 32;
    localparam int IN_SZ_W  = 8;
    localparam int STAT_W   = 3;
    localparam int OCC_W    = 5;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd2;

    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOFIT    = 3'd4;
    localparam logic [STAT_W-1:0] ST_LISTED   = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [IN_TAG_W-1:0] entry_tag;
        logic [IN_SZ_W-1:0]  entry_size;
        logic [IN_SZ_W-1:0]  capacity;
    } ffwq_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [IN_TAG_W-1:0] out_tag;
        logic [IN_SZ_W-1:0]  out_size;
        logic [OCC_W-1:0]    occupancy;
        logic                last;
    } ffwq_out_t;

    // controller to datapath
    typedef struct packed {
        logic              load_req;
        logic              capture_fit;
        logic              insert;
        logic              remove;
        logic              list_clear;
        logic              list_step;
        logic              emit;
        logic [STAT_W-1:0] emit_status;
    } ffwq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] in_func;
        logic [FUNC_W-1:0] req_func;
        logic              empty;
        logic              full;
        logic              fit_any;
        logic              out_free;
        logic              list_last;
    } ffwq_stat_t;

endpackage

`default_nettype wire

/* sv/ffwq_ctrl.sv */
`default_nettype none

module ffwq_ctrl
    import ffwq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire ffwq_stat_t stat,
    output ffwq_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC,
        S_LIST
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    case (stat.in_func)
                        FUNC_INSERT: state_next = S_EXEC;
                        FUNC_REMOVE: state_next = S_CMP;
                        FUNC_LIST: begin
                            cmd.list_clear = 1'b1;
                            state_next     = S_LIST;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_CMP: begin
                cmd.capture_fit = 1'b1;
                state_next      = S_EXEC;
            end
            S_EXEC: begin
                // waits here while the previous result is still held
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                    if (stat.req_func == FUNC_INSERT) begin
                        if (stat.full) begin
                            cmd.emit_status = ST_FULL;
                        end else begin
                            cmd.emit_status = ST_INSERTED;
                            cmd.insert      = 1'b1;
                        end
                    end else if (stat.empty) begin
                        cmd.emit_status = ST_EMPTY;
                    end else if (stat.fit_any) begin
                        cmd.emit_status = ST_REMOVED;
                        cmd.remove      = 1'b1;
                    end else begin
                        cmd.emit_status = ST_NOFIT;
                    end
                end
            end
            S_LIST: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.empty) begin
                        cmd.emit_status = ST_EMPTY;
                        state_next      = S_IDLE;
                    end else begin
                        cmd.emit_status = ST_LISTED;
                        cmd.list_step   = 1'b1;
                        if (stat.list_last) begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* sv/ffwq_dpath.sv */
`default_nettype none

module ffwq_dpath
    import ffwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire ffwq_in_t  s_data,
    input  wire logic      m_ready,
    input  wire ffwq_cmd_t cmd,
    output ffwq_stat_t     stat,
    output logic           out_valid,
    output ffwq_out_t      out_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CMP_W = (SIZE_BITS > IN_SZ_W) ? SIZE_BITS : IN_SZ_W;

    ffwq_in_t             req_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [IDX_W-1:0]     list_idx_reg;
    logic [QUEUE_DEPTH-1:0] fit_reg;
    logic [TAG_BITS-1:0]  tag_reg  [QUEUE_DEPTH];
    logic [SIZE_BITS-1:0] size_reg [QUEUE_DEPTH];
    logic                 out_valid_reg;
    ffwq_out_t            out_reg, out_next;

    logic [QUEUE_DEPTH-1:0] fit_now;
    logic [QUEUE_DEPTH-1:0] pick_onehot;
    logic [QUEUE_DEPTH-1:0] shift_mask;
    logic [TAG_BITS-1:0]    pick_tag;
    logic [SIZE_BITS-1:0]   pick_size;
    logic                   list_last;
    logic                   out_free;

    // parallel compare against the capacity, live entries only
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            fit_now[i] = (CNT_W'(i) < count_reg) &&
                         (CMP_W'(size_reg[i]) <= CMP_W'(req_reg.capacity));
        end
    end

    // oldest fit is the lowest set bit; everything from it upward shifts down
    assign pick_onehot = fit_reg & (~fit_reg + QUEUE_DEPTH'(1));
    assign shift_mask  = ~(pick_onehot - QUEUE_DEPTH'(1));

    always_comb begin
        pick_tag  = '0;
        pick_size = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            pick_tag  = pick_tag  | (tag_reg[i]  & {TAG_BITS{pick_onehot[i]}});
            pick_size = pick_size | (size_reg[i] & {SIZE_BITS{pick_onehot[i]}});
        end
    end

    assign list_last = ((CNT_W'(list_idx_reg) + CNT_W'(1)) == count_reg);
    assign out_free  = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_data;
        end
        if (cmd.capture_fit) begin
            fit_reg <= fit_now;
        end
        if (cmd.insert) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (CNT_W'(i) == count_reg) begin
                    tag_reg[i]  <= TAG_BITS'(req_reg.entry_tag);
                    size_reg[i] <= SIZE_BITS'(req_reg.entry_size);
                end
            end
        end
        if (cmd.remove) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                if (shift_mask[i]) begin
                    tag_reg[i]  <= tag_reg[i+1];
                    size_reg[i] <= size_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            list_idx_reg <= '0;
        end else begin
            if (cmd.insert) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.remove) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.list_clear) begin
                list_idx_reg <= '0;
            end else if (cmd.list_step) begin
                list_idx_reg <= list_idx_reg + IDX_W'(1);
            end
        end
    end

    always_comb begin
        out_next           = '0;
        out_next.status    = cmd.emit_status;
        out_next.occupancy = OCC_W'(count_reg);
        out_next.last      = 1'b1;
        case (cmd.emit_status)
            ST_INSERTED: out_next.occupancy = OCC_W'(count_reg + CNT_W'(1));
            ST_REMOVED: begin
                out_next.occupancy = OCC_W'(count_reg - CNT_W'(1));
                out_next.out_tag   = IN_TAG_W'(pick_tag);
                out_next.out_size  = IN_SZ_W'(pick_size);
            end
            ST_LISTED: begin
                out_next.out_tag  = IN_TAG_W'(tag_reg[list_idx_reg]);
                out_next.out_size = IN_SZ_W'(size_reg[list_idx_reg]);
                out_next.last     = list_last;
            end
            default: out_next.occupancy = OCC_W'(count_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign stat.in_func   = s_data.func;
    assign stat.req_func  = req_reg.func;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.fit_any   = |fit_reg;
    assign stat.out_free  = out_free;
    assign stat.list_last = list_last;

endmodule

`default_nettype wire

/* sv/first_fit_waitlist_queue_unit.sv */
// channel   ports                          moves
// input     s_valid s_ready s_data         one request: func, tag, size, capacity
// result    m_valid m_ready m_data         status, tag, size, occupancy, last
//
// insert passes through execute; remove adds a compare state first (the compare
// is registered before the pick and shift); list reads one entry per cycle out of
// the register file while the output is free, one empty result on an empty queue.
// reset clears the entry count and the control; stored entries need no clearing.
// results sit in an output register; a new request is taken while one waits there,
// and a stalled result holds the controller before it writes the next one.
`default_nettype none

module first_fit_waitlist_queue_unit
    import ffwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = TAG_BITS_DEF,
    parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire ffwq_in_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output ffwq_out_t     m_data
);

    ffwq_cmd_t  cmd;
    ffwq_stat_t stat;

    ffwq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ffwq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS),
        .SIZE_BITS   (SIZE_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

endmodule

`default_nettype wire

/* sv/ffwq_checker.sv */
`default_nettype none

module ffwq_checker
    import ffwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire ffwq_out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_occ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> int'(m_data.occupancy) <= QUEUE_DEPTH)
        else $error("occupancy beyond queue depth");

    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FULL |-> m_data.occupancy == OCC_W'(QUEUE_DEPTH))
        else $error("full reported below depth");

    a_empty_res: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_EMPTY |->
            m_data.occupancy == '0 && m_data.last && m_data.out_tag == '0)
        else $error("empty result malformed");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_LISTED |-> m_data.last)
        else $error("single result without last");

endmodule

bind first_fit_waitlist_queue_unit ffwq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_ffwq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

module tb
    import ffwq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    // operation code with no meaning, dropped by the block
    localparam logic [FUNC_W-1:0] FUNC_BAD = 2'd3;

    // holds the queue contents as they should be and the results still owed
    class waitlist_board;
        logic [IN_TAG_W-1:0] tag_q[DEPTH];
        logic [IN_SZ_W-1:0]  size_q[DEPTH];
        int                  held;
        ffwq_out_t           awaited[$];
        int                  errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function void add_result(logic [STAT_W-1:0] st, logic [IN_TAG_W-1:0] tg,
                                 logic [IN_SZ_W-1:0] sz, int occ, logic lst);
            ffwq_out_t r;
            r.status    = st;
            r.out_tag   = tg;
            r.out_size  = sz;
            r.occupancy = OCC_W'(occ);
            r.last      = lst;
            awaited.push_back(r);
        endfunction

        function void note_request(ffwq_in_t req);
            int pick;
            pick = -1;
            case (req.func)
                FUNC_INSERT: begin
                    if (held >= DEPTH) begin
                        add_result(ST_FULL, '0, '0, held, 1'b1);
                    end else begin
                        tag_q[held]  = req.entry_tag;
                        size_q[held] = req.entry_size;
                        held++;
                        add_result(ST_INSERTED, '0, '0, held, 1'b1);
                    end
                end
                FUNC_REMOVE: begin
                    for (int i = 0; i < held && pick < 0; i++)
                        if (size_q[i] <= req.capacity) pick = i;
                    if (held == 0) begin
                        add_result(ST_EMPTY, '0, '0, 0, 1'b1);
                    end else if (pick < 0) begin
                        add_result(ST_NOFIT, '0, '0, held, 1'b1);
                    end else begin
                        add_result(ST_REMOVED, tag_q[pick], size_q[pick], held - 1, 1'b1);
                        // close the gap, keeping age order
                        for (int i = pick; i + 1 < held; i++) begin
                            tag_q[i]  = tag_q[i+1];
                            size_q[i] = size_q[i+1];
                        end
                        held--;
                    end
                end
                FUNC_LIST: begin
                    if (held == 0) begin
                        add_result(ST_EMPTY, '0, '0, 0, 1'b1);
                    end else begin
                        for (int i = 0; i < held; i++)
                            add_result(ST_LISTED, tag_q[i], size_q[i], held, i == held - 1);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(ffwq_out_t got);
            ffwq_out_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result status=%0d tag=%h size=%0d occ=%0d last=%0b",
                         $time, got.status, got.out_tag, got.out_size, got.occupancy,
                         got.last);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.out_tag !== want.out_tag ||
                got.out_size !== want.out_size || got.occupancy !== want.occupancy ||
                got.last !== want.last) begin
                $display("%0t: expected status=%0d tag=%h size=%0d occ=%0d last=%0b",
                         $time, want.status, want.out_tag, want.out_size, want.occupancy,
                         want.last);
                $display("%0t:   actual status=%0d tag=%h size=%0d occ=%0d last=%0b",
                         $time, got.status, got.out_tag, got.out_size, got.occupancy,
                         got.last);
                errors++;
            end
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ffwq_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ffwq_out_t m_data;

    logic steady = 1'b0;
    waitlist_board board;

    first_fit_waitlist_queue_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: check what was taken at this edge, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
        m_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 18);
    end

    function automatic ffwq_in_t make_request(logic [FUNC_W-1:0] fn, logic [IN_TAG_W-1:0] tg,
                                              logic [IN_SZ_W-1:0] sz, logic [IN_SZ_W-1:0] cap);
        ffwq_in_t req;
        req.func       = fn;
        req.entry_tag  = tg;
        req.entry_size = sz;
        req.capacity   = cap;
        return req;
    endfunction

    // valid is only dropped when a gap is taken, so it is never lowered and raised in one step
    task automatic send_request(ffwq_in_t req);
        if (!steady && $urandom_range(0, 99) < 18) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 18);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        board.note_request(req);
    endtask

    function automatic logic [IN_SZ_W-1:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return IN_SZ_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int                  count;
        int                  roll;
        int                  fill_bias;
        logic [FUNC_W-1:0]   fn;
        logic [IN_TAG_W-1:0] tg;
        logic [IN_SZ_W-1:0]  sz;

        board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(make_request(FUNC_LIST, $urandom, IN_SZ_W'($urandom),
                                  IN_SZ_W'($urandom)));
        send_request(make_request(FUNC_REMOVE, $urandom, IN_SZ_W'($urandom), 8'hff));
        // undefined operation, must be dropped silently
        send_request(make_request(FUNC_BAD, $urandom, IN_SZ_W'($urandom),
                                  IN_SZ_W'($urandom)));
        for (int i = 0; i < DEPTH; i++) begin
            tg = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
            sz = (i == 0) ? 8'hff : (i == 5) ? 8'h00 : IN_SZ_W'($urandom_range(1, 254));
            send_request(make_request(FUNC_INSERT, tg, sz, IN_SZ_W'($urandom)));
        end
        send_request(make_request(FUNC_INSERT, $urandom, IN_SZ_W'($urandom),
                                  IN_SZ_W'($urandom)));
        send_request(make_request(FUNC_LIST, $urandom, IN_SZ_W'($urandom),
                                  IN_SZ_W'($urandom)));
        // zero capacity picks the size-zero entry out of the middle, then nothing fits
        send_request(make_request(FUNC_REMOVE, $urandom, IN_SZ_W'($urandom), 8'h00));
        send_request(make_request(FUNC_REMOVE, $urandom, IN_SZ_W'($urandom), 8'h00));
        send_request(make_request(FUNC_REMOVE, $urandom, IN_SZ_W'($urandom), 8'hff));
        send_request(make_request(FUNC_LIST, $urandom, IN_SZ_W'($urandom),
                                  IN_SZ_W'($urandom)));

        count     = 0;
        fill_bias = 30;
        while (count < 80) begin
            steady = (count >= 40 && count < 70);
            // swing between filling and draining so full and empty are both reached
            if (count % 20 == 0) fill_bias = (count % 40 == 0) ? 65 : 25;
            roll = $urandom_range(0, 99);
            if (roll < 5) fn = FUNC_BAD;
            else if (roll < 13) fn = FUNC_LIST;
            else if (roll < 13 + fill_bias) fn = FUNC_INSERT;
            else fn = FUNC_REMOVE;
            send_request(make_request(fn, $urandom, pick_size(), pick_size()));
            if (fn != FUNC_BAD) count++;
        end
        s_valid <= 1'b0;
        steady  = 1'b0;

        while (board.awaited.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
